@@ src/dvcip_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// dvcip_pkg
// Shared widths, CIP header constants and the job record handed from the
// front end to the back end of the DV CIP packetizer.
// ---------------------------------------------------------------------------
package dvcip_pkg;

  localparam int WORD_W  = 32;
  localparam int SLOT_W  = 9;
  localparam int BYTES_W = 9;
  localparam int CC_W    = 8;
  localparam int QIB_W   = 7;
  localparam int PKT_W   = 9;
  localparam int ACC_W   = 16;

  // Rate ratios N/D per norm
  localparam logic [ACC_W-1:0] NTSC_N = 16'd2436;
  localparam logic [ACC_W-1:0] NTSC_D = 16'd38400;
  localparam logic [ACC_W-1:0] PAL_N  = 16'd1;
  localparam logic [ACC_W-1:0] PAL_D  = 16'd16;

  localparam logic [QIB_W-1:0]   DATA_QUADLETS = 7'd120;
  localparam logic [PKT_W-1:0]   NTSC_PACKETS  = 9'd250;
  localparam logic [PKT_W-1:0]   PAL_PACKETS   = 9'd300;
  localparam logic [BYTES_W-1:0] HDR_BYTES     = 9'd8;
  localparam logic [BYTES_W-1:0] FULL_BYTES    = 9'd488;

  // CIP header bytes
  localparam logic [7:0] CIP_SID   = 8'h01;
  localparam logic [7:0] CIP_DBS   = 8'h78;
  localparam logic [7:0] CIP_RSV   = 8'h00;
  localparam logic [7:0] CIP_FMT   = 8'h80;
  localparam logic [7:0] CIP_PAL   = 8'h80;
  localparam logic [7:0] CIP_NTSC  = 8'h00;
  localparam logic [7:0] CIP_FILL  = 8'hFF;

  // Job queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // Register map: register index taken from paddr[2]
  localparam int         ADDR_W       = 3;
  localparam logic [0:0] REG_PAL_MODE = 1'b0;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [CC_W-1:0]   cc;
    logic              pal;
    logic [SLOT_W-1:0] slot_e;
    logic [SLOT_W-1:0] slot_d;
    logic              has_empty;
    logic              empty_fend;
    logic              has_dhdr;
    logic              has_data;
    logic              data_pend;
    logic              data_fend;
  } dvcip_job_t;

endpackage
`default_nettype wire

@@ src/dv_cip_packetizer_unit.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// dv_cip_packetizer_unit
// DV frame quadlets in, IEC 61883 CIP packet quadlets out.
// ---------------------------------------------------------------------------
// Input channel: data_word/first_of_frame with in_valid/in_stall; a beat is
// taken when in_valid is high and in_stall low. first_of_frame restarts the
// slot and packet counts; once a frame is complete further beats are taken
// and dropped until the next first_of_frame.
// Output channel: one packet quadlet per beat with its slot, packet end,
// packet length, empty flag and frame end, under out_valid/out_stall.
// A taken input beat is written into the job queue, then its first result
// beat into the output register. A data quadlet inside a packet gives one
// output beat; one that opens a packet gives two header beats first, and
// two more when an empty slot comes first. The back end's single output
// register gives one beat per cycle unless out_stall holds it; the
// four-entry job queue absorbs short bursts; in_stall rises only when full.
// Output stall holds the output register and, once the queue fills, the input.
// Reset clears the counters, the rate accumulator, the queue and pal_mode.
// pal_mode sits at byte address 0 of the register port.
// ---------------------------------------------------------------------------
module dv_cip_packetizer_unit #(
  parameter int MAX_SLOTS = 320
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dvcip_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [31:0]                   data_word,
  input  wire logic                          first_of_frame,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [31:0]                        out_word,
  output logic [8:0]                         slot_index,
  output logic                               packet_end,
  output logic [8:0]                         packet_bytes,
  output logic                               empty_packet,
  output logic                               frame_end
);
  import dvcip_pkg::*;

  logic       pal_mode;
  logic       cfg_wr;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_not_empty;
  dvcip_job_t q_job;
  dvcip_job_t q_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_PAL_MODE) ? {31'd0, pal_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_mode <= 1'b0;
    end else if (cfg_wr && (paddr[2] == REG_PAL_MODE)) begin
      pal_mode <= pwdata[0];
    end
  end

  dvcip_front #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .pal_mode      (pal_mode),
    .data_word     (data_word),
    .first_of_frame(first_of_frame),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (q_job)
  );

  dvcip_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .not_empty(q_not_empty),
    .full     (q_full)
  );

  dvcip_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (q_head),
    .job_valid   (q_not_empty),
    .job_pop     (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .slot_index  (slot_index),
    .packet_end  (packet_end),
    .packet_bytes(packet_bytes),
    .empty_packet(empty_packet),
    .frame_end   (frame_end)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_not_empty)
    else $error("job popped from an empty queue");

  a_fend_on_pend: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> packet_end)
    else $error("frame end outside a packet end");

  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_packet) |-> (packet_bytes == HDR_BYTES))
    else $error("empty packet with data length");

endmodule
`default_nettype wire

@@ src/dvcip_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// dvcip_front
// Accepts quadlets, runs the rate accumulator and frame counters, and turns
// each quadlet that is not dropped into a job record for the back end.
// ---------------------------------------------------------------------------
module dvcip_front #(
  parameter int MAX_SLOTS = 320
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pal_mode,
  input  wire logic [31:0]          data_word,
  input  wire logic                 first_of_frame,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 q_full,
  output logic                      q_push,
  output dvcip_pkg::dvcip_job_t     q_job
);
  import dvcip_pkg::*;

  localparam int            SW    = $clog2(MAX_SLOTS + 1);
  localparam logic [SW:0]   MAX_W = (SW + 1)'(MAX_SLOTS);

  logic [ACC_W-1:0] rate_accum;
  logic             rate_pal;
  logic [CC_W-1:0]  continuity_count;
  logic [QIB_W-1:0] quadlet_in_block;
  logic [PKT_W-1:0] data_packets_done;
  logic [SW-1:0]    slots_used;

  logic [SW-1:0]    slots_e;
  logic [PKT_W-1:0] dpd_e;
  logic [QIB_W-1:0] qib_e;
  logic [PKT_W-1:0] ppf;
  logic             drop;
  logic             start;
  logic             pal_l;
  logic [ACC_W-1:0] acc_l;
  logic [ACC_W-1:0] num;
  logic [ACC_W-1:0] den;
  logic             is_empty;
  logic [ACC_W-1:0] acc_a;
  logic [SW:0]      slot_after;
  logic [SW:0]      slot_next1;
  logic             limit;
  logic [QIB_W-1:0] qib1;
  logic             blk_end;
  logic [PKT_W-1:0] dpd1;
  logic             accept;

  always_comb begin
    slots_e    = first_of_frame ? '0 : slots_used;
    dpd_e      = first_of_frame ? '0 : data_packets_done;
    qib_e      = first_of_frame ? '0 : quadlet_in_block;
    ppf        = pal_mode ? PAL_PACKETS : NTSC_PACKETS;
    drop       = ({1'b0, slots_e} >= MAX_W) || (dpd_e >= ppf);
    start      = (qib_e == '0);
    // load the accumulator on first use and latch the norm with it
    pal_l      = (rate_accum == '0) ? pal_mode : rate_pal;
    acc_l      = (rate_accum == '0) ? (pal_l ? PAL_N : NTSC_N) : rate_accum;
    num        = pal_l ? PAL_N : NTSC_N;
    den        = pal_l ? PAL_D : NTSC_D;
    is_empty   = start && (acc_l > den);
    acc_a      = is_empty ? (acc_l - den) : acc_l;
    slot_after = {1'b0, slots_e} + (SW + 1)'(is_empty);
    slot_next1 = slot_after + (SW + 1)'(1);
    limit      = is_empty && (slot_after >= MAX_W);
    qib1       = qib_e + QIB_W'(1);
    blk_end    = (qib1 >= DATA_QUADLETS);
    dpd1       = dpd_e + PKT_W'(1);
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && !drop;

  always_comb begin
    q_job.word       = data_word;
    q_job.cc         = continuity_count;
    q_job.pal        = pal_l;
    q_job.slot_e     = SLOT_W'(slots_e);
    q_job.slot_d     = SLOT_W'(slot_after);
    q_job.has_empty  = is_empty;
    q_job.empty_fend = limit;
    q_job.has_dhdr   = start && !limit;
    q_job.has_data   = !limit;
    q_job.data_pend  = blk_end;
    q_job.data_fend  = blk_end && ((dpd1 >= ppf) || (slot_next1 >= MAX_W));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_accum        <= '0;
      rate_pal          <= 1'b0;
      continuity_count  <= '0;
      quadlet_in_block  <= '0;
      data_packets_done <= '0;
      slots_used        <= '0;
    end else if (accept) begin
      // a dropped beat still restarts the frame counters
      quadlet_in_block  <= qib_e;
      data_packets_done <= dpd_e;
      slots_used        <= slots_e;
      if (!drop) begin
        if (start) begin
          rate_pal   <= pal_l;
          rate_accum <= limit ? acc_a : (acc_a + num);
          if (!limit) begin
            continuity_count <= continuity_count + CC_W'(1);
          end
        end
        if (limit) begin
          slots_used <= slot_after[SW-1:0];
        end else if (blk_end) begin
          quadlet_in_block  <= '0;
          data_packets_done <= dpd1;
          slots_used        <= slot_next1[SW-1:0];
        end else begin
          quadlet_in_block <= qib1;
          slots_used       <= slot_after[SW-1:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ src/dvcip_queue.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// dvcip_queue
// Short job queue between the front end and the back end.
// ---------------------------------------------------------------------------
module dvcip_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire dvcip_pkg::dvcip_job_t push_job,
  input  wire logic                  pop,
  output dvcip_pkg::dvcip_job_t      head,
  output logic                       not_empty,
  output logic                       full
);
  import dvcip_pkg::*;

  dvcip_job_t      mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == (Q_AW + 1)'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (Q_AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (Q_AW + 1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ src/dvcip_back.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// dvcip_back
// Expands each job into its header and data beats, one beat per cycle while
// the output is not stalled, into the output register.
// ---------------------------------------------------------------------------
module dvcip_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dvcip_pkg::dvcip_job_t job,
  input  wire logic                  job_valid,
  output logic                       job_pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [31:0]                out_word,
  output logic [8:0]                 slot_index,
  output logic                       packet_end,
  output logic [8:0]                 packet_bytes,
  output logic                       empty_packet,
  output logic                       frame_end
);
  import dvcip_pkg::*;

  localparam logic [2:0] PH_E0 = 3'd0;
  localparam logic [2:0] PH_E1 = 3'd1;
  localparam logic [2:0] PH_D0 = 3'd2;
  localparam logic [2:0] PH_D1 = 3'd3;
  localparam logic [2:0] PH_W  = 3'd4;

  logic        busy;
  logic [2:0]  phase;
  logic [2:0]  cur;
  logic [2:0]  nxt;
  logic        last;
  logic        load_ok;
  logic [31:0] hdr0;
  logic [31:0] hdr1;
  logic [31:0] b_word;
  logic [8:0]  b_slot;
  logic        b_pend;
  logic [8:0]  b_bytes;
  logic        b_empty;
  logic        b_fend;

  assign hdr0    = {CIP_SID, CIP_DBS, CIP_RSV, job.cc};
  assign hdr1    = {CIP_FMT, (job.pal ? CIP_PAL : CIP_NTSC), CIP_FILL, CIP_FILL};
  assign load_ok = !out_valid || !out_stall;
  assign job_pop = load_ok && job_valid && last;

  always_comb begin
    if (busy) begin
      cur = phase;
    end else if (job.has_empty) begin
      cur = PH_E0;
    end else if (job.has_dhdr) begin
      cur = PH_D0;
    end else begin
      cur = PH_W;
    end

    nxt     = PH_W;
    last    = 1'b0;
    b_word  = job.word;
    b_slot  = job.slot_d;
    b_pend  = 1'b0;
    b_bytes = FULL_BYTES;
    b_empty = 1'b0;
    b_fend  = 1'b0;
    case (cur)
      PH_E0: begin
        b_word  = hdr0;
        b_slot  = job.slot_e;
        b_bytes = HDR_BYTES;
        b_empty = 1'b1;
        nxt     = PH_E1;
      end
      PH_E1: begin
        b_word  = hdr1;
        b_slot  = job.slot_e;
        b_pend  = 1'b1;
        b_bytes = HDR_BYTES;
        b_empty = 1'b1;
        b_fend  = job.empty_fend;
        nxt     = job.has_dhdr ? PH_D0 : PH_W;
        last    = !job.has_dhdr && !job.has_data;
      end
      PH_D0: begin
        b_word = hdr0;
        nxt    = PH_D1;
      end
      PH_D1: begin
        b_word = hdr1;
        nxt    = PH_W;
      end
      PH_W: begin
        b_pend = job.data_pend;
        b_fend = job.data_fend;
        last   = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
      phase     <= PH_E0;
    end else if (load_ok) begin
      out_valid <= job_valid;
      if (job_valid) begin
        busy  <= !last;
        phase <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && job_valid) begin
      out_word     <= b_word;
      slot_index   <= b_slot;
      packet_end   <= b_pend;
      packet_bytes <= b_bytes;
      empty_packet <= b_empty;
      frame_end    <= b_fend;
    end
  end

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for dv_cip_packetizer_unit. Streams DV frame quadlets
// through the input channel with random gaps and output stalls, predicts
// every CIP packet beat and compares each output beat field by field.
// ---------------------------------------------------------------------------
module testbench;
  import dvcip_pkg::*;

  // Slot limit per frame, as the block is built by default
  localparam int SLOT_LIMIT  = 320;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AFTER  = 100;
  localparam int SETTLE      = 10;
  localparam int TAIL        = 20;
  localparam int LIMIT       = 2_000_000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              sof;
    int                gap;
  } quadlet_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [SLOT_W-1:0]  slot;
    logic               pend;
    logic [BYTES_W-1:0] bytes;
    logic               empty;
    logic               fend;
  } cip_beat_t;

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [ADDR_W-1:0]   paddr          = '0;
  logic [31:0]         pwdata         = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [31:0]         data_word      = '0;
  logic                first_of_frame = 1'b0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [31:0]         out_word;
  logic [8:0]          slot_index;
  logic                packet_end;
  logic [8:0]          packet_bytes;
  logic                empty_packet;
  logic                frame_end;

  dv_cip_packetizer_unit #(
    .MAX_SLOTS(SLOT_LIMIT)
  ) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_word(data_word), .first_of_frame(first_of_frame),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word), .slot_index(slot_index), .packet_end(packet_end),
    .packet_bytes(packet_bytes), .empty_packet(empty_packet), .frame_end(frame_end)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Packetizer state as the bench sees it
  logic [ACC_W-1:0]  accum       = '0;  // zero until the first packet opens
  logic [CC_W-1:0]   cont_cnt    = '0;
  logic [QIB_W-1:0]  quad_in_pkt = '0;
  logic [PKT_W-1:0]  pkts_done   = '0;
  logic [SLOT_W-1:0] slots_done  = '0;
  logic              norm_pal    = 1'b0;
  logic              cfg_pal     = 1'b0;

  quadlet_item_t frame_quadlets_q[$];
  cip_beat_t     cip_beats_q[$];

  int pushed     = 0;
  int accepted   = 0;
  int mismatches = 0;
  int beats_seen = 0;
  int calm_left  = 0;

  function automatic void add_beat(logic [WORD_W-1:0] w, logic [SLOT_W-1:0] s, logic pe,
                                   logic [BYTES_W-1:0] b, logic em, logic fe);
    cip_beats_q.push_back('{w, s, pe, b, em, fe});
  endfunction

  function automatic void packetize_quadlet(logic [WORD_W-1:0] w, logic sof);
    logic [PKT_W-1:0]  ppf;
    logic [ACC_W-1:0]  num;
    logic [ACC_W-1:0]  den;
    logic [WORD_W-1:0] hdr1;
    logic [SLOT_W-1:0] slot;
    if (sof) begin
      slots_done  = '0;
      pkts_done   = '0;
      quad_in_pkt = '0;
    end
    ppf = cfg_pal ? PAL_PACKETS : NTSC_PACKETS;
    // frame complete: drop until the next start marker
    if (slots_done >= SLOT_LIMIT || pkts_done >= ppf) return;
    if (quad_in_pkt == '0) begin
      if (accum == '0) begin
        norm_pal = cfg_pal;
        accum    = cfg_pal ? PAL_N : NTSC_N;
      end
      num  = norm_pal ? PAL_N : NTSC_N;
      den  = norm_pal ? PAL_D : NTSC_D;
      hdr1 = {CIP_FMT, (norm_pal ? CIP_PAL : CIP_NTSC), CIP_FILL, CIP_FILL};
      if (accum > den) begin
        accum = accum - den;
        add_beat({CIP_SID, CIP_DBS, CIP_RSV, cont_cnt}, slots_done, 1'b0, HDR_BYTES,
                 1'b1, 1'b0);
        add_beat(hdr1, slots_done, 1'b1, HDR_BYTES, 1'b1, slots_done + 1 >= SLOT_LIMIT);
        slots_done++;
        // an empty packet in the last slot closes the frame and eats the quadlet
        if (slots_done >= SLOT_LIMIT) return;
      end
      add_beat({CIP_SID, CIP_DBS, CIP_RSV, cont_cnt}, slots_done, 1'b0, FULL_BYTES,
               1'b0, 1'b0);
      add_beat(hdr1, slots_done, 1'b0, FULL_BYTES, 1'b0, 1'b0);
      cont_cnt++;
      accum = accum + num;
    end
    quad_in_pkt++;
    if (quad_in_pkt >= DATA_QUADLETS) begin
      slot        = slots_done;
      quad_in_pkt = '0;
      pkts_done++;
      slots_done++;
      add_beat(w, slot, 1'b1, FULL_BYTES, 1'b0,
               pkts_done >= ppf || slots_done >= SLOT_LIMIT);
    end else begin
      add_beat(w, slots_done, 1'b0, FULL_BYTES, 1'b0, 1'b0);
    end
  endfunction

  // Input driver
  quadlet_item_t next_item;
  int            wait_cnt = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      wait_cnt = 0;
    end else begin
      if (in_valid && !in_stall) begin
        packetize_quadlet(data_word, first_of_frame);
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (frame_quadlets_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (wait_cnt < frame_quadlets_q[0].gap) begin
          in_valid <= 1'b0;
          wait_cnt++;
        end else begin
          next_item = frame_quadlets_q.pop_front();
          in_valid       <= 1'b1;
          data_word      <= next_item.word;
          first_of_frame <= next_item.sof;
          wait_cnt = 0;
        end
      end
    end
  end

  // Output back-pressure
  int  stall_left = 0;
  int  quiet_left = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;
  int  roll;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && beats_seen >= HOLD_AFTER) begin
      // hold off long enough for the job queue to fill and stall the input
      out_stall <= 1'b1;
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (quiet_left != 0) begin
      out_stall <= 1'b0;
      quiet_left--;
    end else begin
      roll = $urandom_range(0, 199);
      if (roll < 4) begin
        out_stall <= 1'b0;
        quiet_left = $urandom_range(100, 400);
      end else if (roll < 6) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(8, 40);
      end else if (roll < 40) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Output monitor
  cip_beat_t seen_beat;
  cip_beat_t want_beat;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_beat = '{out_word, slot_index, packet_end, packet_bytes, empty_packet, frame_end};
      beats_seen <= beats_seen + 1;
      if (cip_beats_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected beat: word %h slot %0d end %b bytes %0d empty %b fend %b",
                   seen_beat.word, seen_beat.slot, seen_beat.pend, seen_beat.bytes,
                   seen_beat.empty, seen_beat.fend);
        mismatches++;
      end else begin
        want_beat = cip_beats_q.pop_front();
        if (seen_beat !== want_beat) begin
          if (mismatches < MAX_REPORTS)
            $display("beat %0d: exp word %h slot %0d end %b bytes %0d empty %b fend %b",
                     beats_seen, want_beat.word, want_beat.slot, want_beat.pend,
                     want_beat.bytes, want_beat.empty, want_beat.fend, "\n",
                     "         got word %h slot %0d end %b bytes %0d empty %b fend %b",
                     seen_beat.word, seen_beat.slot, seen_beat.pend, seen_beat.bytes,
                     seen_beat.empty, seen_beat.fend);
          mismatches++;
        end
      end
    end
  end

  int cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("dv_cip_packetizer_unit: mismatch");
      $finish;
    end
  end

  task automatic queue_quadlet(logic [WORD_W-1:0] w, logic sof);
    quadlet_item_t it;
    int            r;
    it.word = w;
    it.sof  = sof;
    if (calm_left > 0) begin
      calm_left--;
      it.gap = 0;
    end else begin
      r = $urandom_range(0, 199);
      if (r < 2) begin
        calm_left = $urandom_range(100, 400);
        it.gap    = 0;
      end else if (r < 6) begin
        it.gap = $urandom_range(8, 40);
      end else if (r < 50) begin
        it.gap = $urandom_range(1, 3);
      end else begin
        it.gap = 0;
      end
    end
    frame_quadlets_q.push_back(it);
    pushed++;
  endtask

  task automatic queue_random_frames(int count);
    int                n;
    int                len;
    logic              sof;
    logic [WORD_W-1:0] w;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(120, 260) : $urandom_range(1, 12);
      // now and then carry on without a start marker
      sof = ($urandom_range(0, 19) != 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 15) == 0)
          w = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        else
          w = $urandom();
        queue_quadlet(w, (i == 0) ? sof : ($urandom_range(0, 99) == 0));
      end
      n += len;
    end
  endtask

  task automatic wait_idle();
    while (!(accepted == pushed && cip_beats_q.size() == 0)) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_pal_mode(logic v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_PAL_MODE, 2'b00};
    pwdata  <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_pal = v;
  endtask

  initial begin
    logic start_pal;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // the norm in force at the first packet is latched for the whole run
    start_pal = $urandom_range(0, 1);
    write_pal_mode(start_pal);

    queue_quadlet(32'h0000_0000, 1'b0);  // no start marker after reset
    queue_quadlet(32'hFFFF_FFFF, 1'b0);
    queue_quadlet(32'h8000_0001, 1'b0);
    queue_quadlet(32'h7FFF_FFFE, 1'b0);
    queue_quadlet(32'hAAAA_5555, 1'b0);
    queue_quadlet(32'h5555_AAAA, 1'b1);  // abandon the packet mid-way
    queue_quadlet(32'hFFFF_FFFF, 1'b0);
    queue_quadlet(32'h0000_0000, 1'b1);
    queue_quadlet(32'h0123_4567, 1'b1);
    queue_quadlet(32'hFEDC_BA98, 1'b1);
    queue_quadlet(32'hFFFF_FFFF, 1'b1);
    // packet openings, one per quadlet, that step the rate accumulator
    for (int i = 0; i < 8; i++)
      queue_quadlet(i[0] ? 32'hFFFF_FFFF : 32'h0000_0000, 1'b1);
    wait_idle();

    // flip the norm after the accumulator has loaded
    write_pal_mode(~start_pal);
    for (int i = 0; i < 6; i++)
      queue_quadlet(i[0] ? 32'h0000_0000 : 32'hFFFF_FFFF, 1'b1);
    wait_idle();

    queue_random_frames(200);
    wait_idle();

    write_pal_mode($urandom_range(0, 1));
    queue_random_frames(200);

    while (!(accepted == pushed && cip_beats_q.size() == 0)) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0 && cip_beats_q.size() == 0)
      $display("dv_cip_packetizer_unit: match");
    else
      $display("dv_cip_packetizer_unit: mismatch");
    $finish;
  end

endmodule
